// File: hw/rtl/cxs_pkg.sv
// Shared types, constants and coefficient table for the xy to sRGB converter.
`timescale 1ns / 1ps

package cxs_pkg;

    localparam int NUM_ENDPOINTS = 256;
    localparam int EP_AW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam int REM_W = 48;

    localparam logic [31:0] LIN_THRESHOLD = 32'd13446684;
    localparam logic [19:0] SLOPE_Q16 = 20'd846725;
    localparam logic [16:0] GAIN_Q16 = 17'd69140;
    localparam logic signed [44:0] OFFSET_Q42 = 45'sd241892558111;
    localparam logic signed [44:0] ROUND_Q26 = 45'sd33554432;
    localparam logic [44:0] ROUND_Q32 = 45'd2147483648;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        OP_SQRT = 2'd0,
        OP_CBRT = 2'd1,
        OP_DIV  = 2'd2
    } iter_op_t;

    typedef struct packed {
        logic       start;
        iter_op_t   op;
        logic [63:0] n;
        logic [15:0] d;
    } iter_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] res;
    } iter_stat_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  endpoint;
        logic [15:0] value;
    } wr_req_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
    } pair_t;

    typedef struct packed {
        logic        zero_y;
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
    } color_t;

    function automatic logic signed [18:0] coef(input logic [1:0] ch, input logic [1:0] k);
        logic signed [18:0] c;
        c = 19'sd0;
        case ({ch, k})
            4'b00_00: c = 19'sd212376;
            4'b00_01: c = -19'sd100742;
            4'b00_10: c = -19'sd32676;
            4'b01_00: c = -19'sd63498;
            4'b01_01: c = 19'sd122932;
            4'b01_10: c = 19'sd2720;
            4'b10_00: c = 19'sd3650;
            4'b10_01: c = -19'sd13369;
            4'b10_10: c = 19'sd69272;
            default:  c = 19'sd0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/cxs_store.sv
// Endpoint chromaticity memory with read-modify-write and per-entry valid bits.
`timescale 1ns / 1ps

module cxs_store (
    input  logic            aclk,
    input  logic            aresetn,
    input  cxs_pkg::wr_req_t req,
    output cxs_pkg::pair_t   pair
);
    import cxs_pkg::*;

    logic [31:0]      mem [NUM_ENDPOINTS];
    logic             vld_reg [NUM_ENDPOINTS];
    logic [31:0]      rd_data_reg;
    logic             rd_vld_reg;
    logic             pend_reg;
    logic             kind_reg;
    logic             oob_reg;
    logic [15:0]      value_reg;
    logic [EP_AW-1:0] idx_reg;
    logic [EP_AW-1:0] idx;
    logic             oob;
    logic [31:0]      old_pair;
    logic [31:0]      new_pair;

    assign idx = req.endpoint[EP_AW-1:0];
    assign oob = ({1'b0, req.endpoint} >= 9'(NUM_ENDPOINTS));

    always_comb begin
        old_pair = rd_vld_reg ? rd_data_reg : 32'd0;
        if (kind_reg) begin
            new_pair = {old_pair[31:16], value_reg};
        end else begin
            new_pair = {value_reg, old_pair[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            rd_data_reg <= mem[idx];
        end
        if (pend_reg && !oob_reg) begin
            mem[idx_reg] <= new_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            kind_reg  <= req.kind;
            value_reg <= req.value;
            idx_reg   <= idx;
            oob_reg   <= oob;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            pend_reg <= req.valid;
            if (req.valid) begin
                rd_vld_reg <= vld_reg[idx];
            end
            if (pend_reg && !oob_reg) begin
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign pair.valid = pend_reg;
    assign pair.x     = oob_reg ? 16'd0 : new_pair[31:16];
    assign pair.y     = oob_reg ? 16'd0 : new_pair[15:0];

endmodule

// File: hw/rtl/cxs_iter.sv
// Shared bit-serial unit for square root, cube root and division.
`timescale 1ns / 1ps

module cxs_iter (
    input  logic               aclk,
    input  logic               aresetn,
    input  cxs_pkg::iter_req_t  req,
    output cxs_pkg::iter_stat_t stat
);
    import cxs_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    iter_op_t         op_reg;
    logic [63:0]      n_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] sq_reg;
    logic [31:0]      root_reg;
    logic [15:0]      d_reg;

    logic [63:0]      n_next;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] sq_next;
    logic [31:0]      root_next;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
        shifted = '0;
        trial   = '0;
        n_next  = n_reg;
        sq_next = sq_reg;
        unique case (op_reg)
            OP_SQRT: begin
                shifted = {rem_reg[REM_W-3:0], n_reg[63:62]};
                trial   = {14'd0, root_reg, 2'b01};
                n_next  = {n_reg[61:0], 2'b00};
            end
            OP_CBRT: begin
                shifted = {rem_reg[REM_W-4:0], n_reg[63:61]};
                trial   = (sq_reg << 3) + (sq_reg << 2) + {14'd0, root_reg, 2'b00}
                        + {15'd0, root_reg, 1'b0} + 48'd1;
                n_next  = {n_reg[60:0], 3'b000};
            end
            OP_DIV: begin
                shifted = {rem_reg[REM_W-2:0], n_reg[63]};
                trial   = {32'd0, d_reg};
                n_next  = {n_reg[62:0], 1'b0};
            end
            default: begin
                shifted = rem_reg;
                trial   = '1;
            end
        endcase
        ge        = (shifted >= trial);
        rem_next  = ge ? (shifted - trial) : shifted;
        root_next = {root_reg[30:0], ge};
        if (op_reg == OP_CBRT) begin
            sq_next = ge ? ((sq_reg << 2) + {14'd0, root_reg, 2'b00} + 48'd1) : (sq_reg << 2);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg   <= req.op;
            d_reg    <= req.d;
            root_reg <= 32'd0;
            sq_reg   <= '0;
            unique case (req.op)
                OP_CBRT: begin
                    n_reg   <= {req.n[62:0], 1'b0};
                    rem_reg <= '0;
                end
                OP_DIV: begin
                    n_reg   <= {req.n[15:0], 48'd0};
                    rem_reg <= {32'd0, req.n[31:16]};
                end
                default: begin
                    n_reg   <= req.n;
                    rem_reg <= '0;
                end
            endcase
        end else if (busy_reg) begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            sq_reg   <= sq_next;
            root_reg <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_CBRT) ? 5'd20 : 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.res  = root_reg;

endmodule

// File: hw/rtl/cxs_color.sv
// Sequencer for the color matrix and the sRGB transfer curve of one endpoint.
`timescale 1ns / 1ps

module cxs_color (
    input  logic                aclk,
    input  logic                aresetn,
    input  cxs_pkg::pair_t      pair,
    output cxs_pkg::iter_req_t  iter_req,
    input  cxs_pkg::iter_stat_t iter_stat,
    output logic                res_valid,
    input  logic                res_ready,
    output cxs_pkg::color_t     res
);
    import cxs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MAC  = 12'b0000_0000_0010,
        S_CHK  = 12'b0000_0000_0100,
        S_DIV  = 12'b0000_0000_1000,
        S_LIN  = 12'b0000_0001_0000,
        S_SQ1  = 12'b0000_0010_0000,
        S_SQ2  = 12'b0000_0100_0000,
        S_CB   = 12'b0000_1000_0000,
        S_SQ3  = 12'b0001_0000_0000,
        S_MT   = 12'b0010_0000_0000,
        S_NEXT = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [15:0]        x_reg;
    logic [15:0]        y_reg;
    logic [1:0]         ch_reg;
    logic [1:0]         k_reg;
    logic signed [39:0] acc_reg;
    logic [31:0]        v_reg;
    logic [31:0]        q4_reg;
    logic [25:0]        p_reg;
    logic [16:0]        chan_reg;
    color_t             col_reg;

    logic signed [17:0] z_val;
    logic signed [17:0] op_sel;
    logic signed [36:0] prod;
    logic signed [39:0] acc_sum;
    logic signed [39:0] y_lim;
    logic               acc_le0;
    logic               acc_ge;
    logic [43:0]        lin_prod;
    logic [44:0]        lin_sum;
    logic [16:0]        lin_res;
    logic [57:0]        pq;
    logic [42:0]        gain_prod;
    logic signed [44:0] t_val;
    logic signed [44:0] t_rnd;
    logic [18:0]        o_val;
    logic [16:0]        mt_res;

    always_comb begin
        z_val = 18'sd65536 - $signed({2'b00, x_reg}) - $signed({2'b00, y_reg});
        case (k_reg)
            2'd0:    op_sel = $signed({2'b00, x_reg});
            2'd1:    op_sel = $signed({2'b00, y_reg});
            default: op_sel = z_val;
        endcase
        prod    = coef(ch_reg, k_reg) * op_sel;
        acc_sum = acc_reg + 40'(prod);
        y_lim   = $signed({8'd0, y_reg, 16'd0});
        acc_le0 = (acc_reg <= 40'sd0);
        acc_ge  = (acc_reg >= y_lim);

        lin_prod = v_reg[23:0] * SLOPE_Q16;
        lin_sum  = 45'(lin_prod) + ROUND_Q32;
        lin_res  = {4'd0, lin_sum[44:32]};

        pq        = q4_reg * iter_stat.res[25:0];
        gain_prod = p_reg * GAIN_Q16;
        t_val     = $signed({2'b00, gain_prod}) - OFFSET_Q42;
        t_rnd     = t_val + ROUND_Q26;
        o_val     = t_rnd[44:26];
        if (t_val < 45'sd0) begin
            mt_res = 17'd0;
        end else if (o_val > 19'(ONE_Q16)) begin
            mt_res = ONE_Q16;
        end else begin
            mt_res = o_val[16:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        iter_req.start = 1'b0;
        iter_req.op    = OP_SQRT;
        iter_req.n     = 64'd0;
        iter_req.d     = y_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (pair.valid) begin
                    state_next = (pair.y == 16'd0) ? S_DONE : S_MAC;
                end
            end
            S_MAC: begin
                if (k_reg == 2'd2) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (acc_le0 || acc_ge) begin
                    state_next = S_NEXT;
                end else begin
                    iter_req.start = 1'b1;
                    iter_req.op    = OP_DIV;
                    iter_req.n     = {32'd0, acc_reg[31:0]};
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                if (iter_stat.done) begin
                    if (iter_stat.res < LIN_THRESHOLD) begin
                        state_next = S_LIN;
                    end else begin
                        iter_req.start = 1'b1;
                        iter_req.n     = {iter_stat.res, 32'd0};
                        state_next     = S_SQ1;
                    end
                end
            end
            S_LIN: state_next = S_NEXT;
            S_SQ1: begin
                if (iter_stat.done) begin
                    iter_req.start = 1'b1;
                    iter_req.n     = {iter_stat.res, 32'd0};
                    state_next     = S_SQ2;
                end
            end
            S_SQ2: begin
                if (iter_stat.done) begin
                    iter_req.start = 1'b1;
                    iter_req.op    = OP_CBRT;
                    iter_req.n     = {1'b0, v_reg, 31'd0};
                    state_next     = S_CB;
                end
            end
            S_CB: begin
                if (iter_stat.done) begin
                    iter_req.start = 1'b1;
                    iter_req.n     = {1'b0, iter_stat.res, 31'd0};
                    state_next     = S_SQ3;
                end
            end
            S_SQ3: begin
                if (iter_stat.done) begin
                    state_next = S_MT;
                end
            end
            S_MT:   state_next = S_NEXT;
            S_NEXT: state_next = (ch_reg == 2'd2) ? S_DONE : S_MAC;
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (pair.valid) begin
                    x_reg   <= pair.x;
                    y_reg   <= pair.y;
                    ch_reg  <= 2'd0;
                    k_reg   <= 2'd0;
                    acc_reg <= 40'sd0;
                    col_reg <= {(pair.y == 16'd0), 51'd0};
                end
            end
            S_MAC: begin
                acc_reg <= acc_sum;
                k_reg   <= k_reg + 2'd1;
            end
            S_CHK: begin
                chan_reg <= acc_le0 ? 17'd0 : ONE_Q16;
            end
            S_DIV: begin
                if (iter_stat.done) begin
                    v_reg <= iter_stat.res;
                end
            end
            S_LIN: chan_reg <= lin_res;
            S_SQ2: begin
                if (iter_stat.done) begin
                    q4_reg <= iter_stat.res;
                end
            end
            S_SQ3: begin
                if (iter_stat.done) begin
                    p_reg <= pq[57:32];
                end
            end
            S_MT: chan_reg <= mt_res;
            S_NEXT: begin
                case (ch_reg)
                    2'd0:    col_reg.red   <= chan_reg;
                    2'd1:    col_reg.green <= chan_reg;
                    default: col_reg.blue  <= chan_reg;
                endcase
                ch_reg  <= ch_reg + 2'd1;
                k_reg   <= 2'd0;
                acc_reg <= 40'sd0;
            end
            default: ;
        endcase
    end

    assign res_valid = (state_reg == S_DONE);
    assign res       = col_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_req.start |-> !iter_stat.busy)
        else $error("Root unit started while busy.");

    a_lin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIN) |-> (v_reg < LIN_THRESHOLD))
        else $error("Linear segment entered above the threshold.");

    a_zero_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.zero_y) |-> (res.red == 17'd0 && res.green == 17'd0
                                       && res.blue == 17'd0))
        else $error("Zero y result carries nonzero color.");

endmodule

// File: hw/rtl/cie_xy_to_srgb_converter_top.sv
// Top level of the CIE xy to gamma-corrected sRGB converter.
`timescale 1ns / 1ps

// Each input transfer writes the x or y chromaticity of one endpoint and yields one
// output transfer with that endpoint's sRGB color in Q1.16. One item is processed at a
// time. Zero y skips the channel work; items take longest when all three
// channels take the power segment, which runs on the shared bit-serial root and
// divide unit (32 steps per square root or division, 21 per cube root, four roots and
// one division per channel). A finished result waits in the output register while the
// next item is accepted.
module cie_xy_to_srgb_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // endpoint[7:0], value[23:8]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_endpoint[7:0], red[24:8], green[41:25], blue[58:42]
    output logic        m_tuser    // zero_y
);
    import cxs_pkg::*;

    logic        busy_reg;
    logic [7:0]  ep_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        s_accept;
    logic        res_valid;
    logic        res_ready;
    logic        take;
    wr_req_t     wr_req;
    pair_t       pair;
    iter_req_t   iter_req;
    iter_stat_t  iter_stat;
    color_t      color;

    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign res_ready = !m_tvalid_reg || m_tready;
    assign take      = res_valid && res_ready;

    assign wr_req.valid    = s_accept;
    assign wr_req.kind     = s_tuser;
    assign wr_req.endpoint = s_tdata[7:0];
    assign wr_req.value    = s_tdata[23:8];

    cxs_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (wr_req),
        .pair    (pair)
    );

    cxs_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .stat    (iter_stat)
    );

    cxs_color u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pair      (pair),
        .iter_req  (iter_req),
        .iter_stat (iter_stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (color)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ep_reg <= s_tdata[7:0];
        end
        if (take) begin
            m_tdata_reg <= {5'd0, color.blue, color.green, color.red, ep_reg};
            m_tuser_reg <= color.zero_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                busy_reg <= 1'b1;
            end else if (take) begin
                busy_reg <= 1'b0;
            end
            if (take) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the CIE xy to sRGB converter with randomized stream handshakes.
`timescale 1ns / 1ps

module testbench;
    import cxs_pkg::*;

    typedef struct {
        logic [7:0]  ep;
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
        logic        zero_y;
    } color_exp_t;

    typedef struct {
        logic        kind;
        logic [7:0]  ep;
        logic [15:0] value;
        logic        typed;
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
        logic        zero_y;
    } stim_row_t;

    localparam logic KIND_X = 1'b0;
    localparam logic KIND_Y = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    logic [15:0] x_mem [0:NUM_ENDPOINTS-1];
    logic [15:0] y_mem [0:NUM_ENDPOINTS-1];
    color_exp_t  color_q[$];
    int          errors;
    bit          drain;

    cie_xy_to_srgb_converter_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] cbrt_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [16:0] gamma_channel(input longint num, input logic [15:0] yv);
        logic [63:0] v;
        logic [63:0] q4;
        logic [63:0] s6;
        logic [63:0] p;
        longint      t;
        longint      o;
        if (num <= 0) return 17'd0;
        if (64'(num) >= (64'(yv) << 16)) return ONE_Q16;
        v = (64'(num) << 16) / 64'(yv);
        if (v < 64'(LIN_THRESHOLD))
            return 17'((v * 64'(SLOPE_Q16) + (64'd1 << 31)) >> 32);
        q4 = sqrt_floor(sqrt_floor(v << 32) << 32);
        s6 = sqrt_floor(cbrt_floor(v << 31) << 31);
        p = (q4 * s6) >> 32;
        t = longint'(p) * longint'(GAIN_Q16) - longint'(OFFSET_Q42);
        if (t < 0) return 17'd0;
        o = (t + (longint'(1) << 25)) >>> 26;
        if (o > 65536) o = 65536;
        return 17'(o);
    endfunction

    function automatic color_exp_t predict_color(input logic kind, input logic [7:0] ep,
                                                 input logic [15:0] value);
        color_exp_t e;
        longint     x;
        longint     y;
        longint     z;
        if (kind == KIND_X) x_mem[ep] = value;
        else y_mem[ep] = value;
        x = x_mem[ep];
        y = y_mem[ep];
        e.ep = ep;
        e.red = 0;
        e.green = 0;
        e.blue = 0;
        e.zero_y = (y == 0);
        if (y != 0) begin
            z = 65536 - x - y;
            e.red = gamma_channel(212376 * x - 100742 * y - 32676 * z, y_mem[ep]);
            e.green = gamma_channel(-63498 * x + 122932 * y + 2720 * z, y_mem[ep]);
            e.blue = gamma_channel(3650 * x - 13369 * y + 69272 * z, y_mem[ep]);
        end
        return e;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Typed rows expect their written-in color; all other rows expect the predicted one.
    task automatic send_item(input logic kind, input logic [7:0] ep, input logic [15:0] value,
                             input bit check_typed, input color_exp_t typed_exp);
        color_exp_t e;
        int         g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        e = predict_color(kind, ep, value);
        if (check_typed) e = typed_exp;
        color_q.push_back(e);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {value, ep};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        color_exp_t e;
        logic [7:0] got_ep;
        logic [16:0] got_r;
        logic [16:0] got_g;
        logic [16:0] got_b;
        if (aresetn && m_tvalid && m_tready) begin
            got_ep = m_tdata[7:0];
            got_r = m_tdata[24:8];
            got_g = m_tdata[41:25];
            got_b = m_tdata[58:42];
            if (color_q.size() == 0) begin
                $display("%0t: unexpected transfer ep %0d", $time, got_ep);
                errors++;
            end else begin
                e = color_q.pop_front();
                if (got_ep !== e.ep) begin
                    $display("%0t: endpoint expected %0d actual %0d", $time, e.ep, got_ep);
                    errors++;
                end
                if (got_r !== e.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, e.red, got_r);
                    errors++;
                end
                if (got_g !== e.green) begin
                    $display("%0t: green expected %0d actual %0d", $time, e.green, got_g);
                    errors++;
                end
                if (got_b !== e.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, e.blue, got_b);
                    errors++;
                end
                if (m_tuser !== e.zero_y) begin
                    $display("%0t: zero_y expected %0b actual %0b", $time, e.zero_y, m_tuser);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls in bursts, with calm stretches where it is always ready.
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (drain || $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge aclk);
            end else begin
                n = gap_len();
                m_tready <= (n == 0);
                repeat (n == 0 ? 1 : n) @(posedge aclk);
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        stim_row_t  rows[$];
        color_exp_t te;
        logic [7:0] ep;
        logic [15:0] xv;
        logic [15:0] yv;
        int         wait_cycles;
        errors = 0;
        drain = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        for (int i = 0; i < NUM_ENDPOINTS; i++) begin
            x_mem[i] = 0;
            y_mem[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero y after reset and at explicit writes gives black with the flag set; others predicted.
        rows.push_back('{KIND_X, 8'd0, 16'hFFFF, 1, 17'd0, 17'd0, 17'd0, 1'b1});
        rows.push_back('{KIND_X, 8'd255, 16'h5555, 1, 17'd0, 17'd0, 17'd0, 1'b1});
        rows.push_back('{KIND_Y, 8'd7, 16'h0000, 1, 17'd0, 17'd0, 17'd0, 1'b1});
        rows.push_back('{KIND_Y, 8'd0, 16'hFFFF, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd0, 16'h0000, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd0, 16'h0001, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd255, 16'hFFFF, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd1, 16'd20493, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd1, 16'd21567, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd2, 16'd41943, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd2, 16'd21627, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd3, 16'd19661, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd3, 16'd39322, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd4, 16'd9830, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd4, 16'd3932, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd5, 16'd50000, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd5, 16'd50000, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_X, 8'd6, 16'd21000, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd6, 16'd22000, 0, 0, 0, 0, 0});
        rows.push_back('{KIND_Y, 8'd6, 16'd0, 1, 17'd0, 17'd0, 17'd0, 1'b1});
        foreach (rows[i]) begin
            te = '{rows[i].ep, rows[i].red, rows[i].green, rows[i].blue, rows[i].zero_y};
            send_item(rows[i].kind, rows[i].ep, rows[i].value, rows[i].typed, te);
        end

        // Mostly x/y pairs over broad chromaticity ranges, mostly on endpoints 0 to 15, plus raw noise.
        for (int i = 0; i < 650; i++) begin
            ep = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0) begin
                send_item(1'($urandom_range(0, 1)), ep, 16'($urandom), 0, te);
                send_item(1'($urandom_range(0, 1)), ep, 16'($urandom), 0, te);
            end else begin
                xv = 16'($urandom_range(6000, 48000));
                yv = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 300))
                                                  : 16'($urandom_range(2000, 55000));
                send_item(KIND_X, ep, xv, 0, te);
                send_item(KIND_Y, ep, yv, 0, te);
            end
        end
        s_tvalid <= 1'b0;

        drain = 1;
        wait_cycles = 0;
        while (color_q.size() != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (600) @(posedge aclk);
        if (errors == 0 && color_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            if (color_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, color_q.size());
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/cxs_pkg.sv
hw/rtl/cxs_store.sv
hw/rtl/cxs_iter.sv
hw/rtl/cxs_color.sv
hw/rtl/cie_xy_to_srgb_converter_top.sv
dv/testbench.sv
